// File: design/assert_macros.svh
// Assertion macros included by the frame receiver core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/srxl_pkg.sv
// Types and constants of the SRXL frame receiver.
`default_nettype none
package srxl_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int IDX_W = $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] HDR_SHORT = 8'hA1;
	localparam logic [7:0] HDR_LONG = 8'hA2;
	localparam logic [CNT_W-1:0] SHORT_COUNT = CNT_W'(12);
	localparam logic [CNT_W-1:0] LONG_COUNT = CNT_W'(16);
	localparam logic [7:0] TIMEOUT_RESET = 8'd5;
	localparam logic [4:0] MIN_CH_RESET = 5'd12;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CH = 1'b1;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  channel_index;
		logic [15:0] channel_value;
		logic        frame_is_short;
		logic        seen_short_frame;
		logic        last;
	} out_item_t;

endpackage
`default_nettype wire

// File: design/srxl_frame_receiver_core.sv
// SRXL frame receiver: byte parser, channel store and result emitter.
// The parser takes an input item whenever no emission is in progress; the first
// result of a frame passes the emit flag, the read stage and the output register
// after the second CRC byte is taken. A new store read issues only when no read is
// pending and the output register is free; input stalls until the last store read issues.
// Reset clears all control state at once; the channel store reads as zero
// through per-entry valid bits, so no clearing pass follows reset.
`default_nettype none
`include "assert_macros.svh"
module srxl_frame_receiver_core
	import srxl_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  in_item_t                   in_data,
	output logic                       out_valid,
	input  wire                        out_stall,
	output out_item_t                  out_data,
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [CFG_W-1:0]           cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DATA12,
		PH_DATA16,
		PH_CRC1,
		PH_CRC2
	} phase_t;

	phase_t                 phase_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   half_q;
	logic [7:0]             held_q;
	logic [7:0]             quiet_q;
	logic                   short_seen_q;
	logic                   short_kind_q;
	logic [7:0]             timeout_q;
	logic [4:0]             min_ch_q;
	logic [MAX_CHANNELS-1:0] valid_q;

	logic                   emit_q;
	logic [CNT_W-1:0]       emit_idx_q;
	logic [CNT_W-1:0]       emit_n_q;
	logic                   emit_kind_q;
	logic                   emit_seen_q;

	logic                   rd_pend_s1;
	logic [CNT_W-1:0]       rd_idx_s1;
	logic                   rd_last_s1;
	logic                   rd_ok_s1;
	logic [15:0]            rd_data_s1;

	logic                   out_valid_q;
	out_item_t              out_q;

	logic [15:0]            store [MAX_CHANNELS];

	logic                   in_acc;
	logic                   is_byte;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [CNT_W-1:0]       cnt_inc;
	logic [7:0]             quiet_inc;
	logic [CNT_W-1:0]       min_ext;
	logic [CNT_W-1:0]       cnt_max;
	logic [CNT_W-1:0]       emit_n;
	logic                   rd_go;
	logic [CNT_W-1:0]       emit_idx_inc;
	logic                   rd_last;

	assign in_stall  = emit_q;
	assign in_acc    = in_valid && !in_stall;
	assign is_byte   = (in_data.req_type == REQ_BYTE);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign quiet_inc = (quiet_q == 8'hFF) ? quiet_q : quiet_q + 8'd1;

	// Write a channel word on the low byte of a pair
	assign wr_en   = in_acc && is_byte && half_q
		&& (phase_q == PH_DATA12 || phase_q == PH_DATA16);
	assign wr_addr = cnt_q[IDX_W-1:0];

	// Emit count: larger of frame count and minimum, capped at the store depth
	assign min_ext = CNT_W'(min_ch_q);
	assign cnt_max = (cnt_q > min_ext) ? cnt_q : min_ext;
	assign emit_n  = (cnt_max > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : cnt_max;

	// Issue a store read when the output register is free at the next edge
	assign rd_go        = emit_q && !rd_pend_s1 && (!out_valid_q || !out_stall);
	assign emit_idx_inc = emit_idx_q + CNT_W'(1);
	assign rd_last      = (emit_idx_inc == emit_n_q);

	// Channel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= {held_q, in_data.rx_byte};
		end
		rd_data_s1 <= store[emit_idx_q[IDX_W-1:0]];
	end

	// Hold the high byte of a channel word until its low byte arrives
	always_ff @(posedge clk) begin
		if (in_acc && is_byte && !half_q
			&& (phase_q == PH_DATA12 || phase_q == PH_DATA16)) begin
			held_q <= in_data.rx_byte;
		end
	end

	// Parser, configuration and emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cnt_q        <= '0;
			half_q       <= 1'b0;
			quiet_q      <= '0;
			short_seen_q <= 1'b0;
			short_kind_q <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
			min_ch_q     <= MIN_CH_RESET;
			valid_q      <= '0;
			emit_q       <= 1'b0;
			emit_idx_q   <= '0;
			emit_n_q     <= '0;
			emit_kind_q  <= 1'b0;
			emit_seen_q  <= 1'b0;
			rd_pend_s1   <= 1'b0;
			rd_idx_s1    <= '0;
			rd_last_s1   <= 1'b0;
			rd_ok_s1     <= 1'b0;
		end else begin
			// take configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_MIN_CH:  min_ch_q  <= cfg_data[4:0];
					default: ;
				endcase
			end

			// advance the parser on each accepted item
			if (in_acc) begin
				if (!is_byte) begin
					quiet_q <= quiet_inc;
					if (phase_q != PH_IDLE && quiet_inc > timeout_q) begin
						phase_q <= PH_IDLE;
					end
				end else begin
					quiet_q <= '0;
					case (phase_q)
						PH_DATA12, PH_DATA16: begin
							if (phase_q == PH_DATA12) begin
								short_seen_q <= 1'b1;
							end
							if (!half_q) begin
								half_q <= 1'b1;
							end else begin
								valid_q[wr_addr] <= 1'b1;
								cnt_q  <= cnt_inc;
								half_q <= 1'b0;
								if ((phase_q == PH_DATA12 && cnt_inc == SHORT_COUNT)
									|| cnt_inc == LONG_COUNT) begin
									phase_q <= PH_CRC1;
								end
							end
						end
						PH_CRC1: begin
							phase_q <= PH_CRC2;
						end
						PH_CRC2: begin
							phase_q     <= PH_IDLE;
							emit_q      <= 1'b1;
							emit_idx_q  <= '0;
							emit_n_q    <= emit_n;
							emit_kind_q <= short_kind_q;
							emit_seen_q <= short_seen_q;
						end
						default: begin
							if (in_data.rx_byte == HDR_SHORT) begin
								phase_q      <= PH_DATA12;
								short_kind_q <= 1'b1;
							end else if (in_data.rx_byte == HDR_LONG) begin
								phase_q      <= PH_DATA16;
								short_kind_q <= 1'b0;
							end else begin
								phase_q <= PH_IDLE;
							end
							cnt_q  <= '0;
							half_q <= 1'b0;
						end
					endcase
				end
			end

			// step the emission through the store
			rd_pend_s1 <= rd_go;
			if (rd_go) begin
				rd_idx_s1  <= emit_idx_q;
				rd_last_s1 <= rd_last;
				rd_ok_s1   <= valid_q[emit_idx_q[IDX_W-1:0]];
				emit_idx_q <= emit_idx_inc;
				if (rd_last) begin
					emit_q <= 1'b0;
				end
			end
		end
	end

	// Output register: load from a returning read, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_q.channel_index    <= rd_idx_s1[3:0];
			out_q.channel_value    <= rd_ok_s1 ? rd_data_s1 : 16'h0000;
			out_q.frame_is_short   <= emit_kind_q;
			out_q.seen_short_frame <= emit_seen_q;
			out_q.last             <= rd_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_IMPLIES(a_emit_in_idle, clk, arst_n, emit_q, phase_q == PH_IDLE)
	`ASSERT_IMPLIES(a_read_into_free_reg, clk, arst_n, rd_pend_s1, !out_valid_q)
	`ASSERT_IMPLIES(a_count_in_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_CHANNELS))
	`ASSERT_NEXT(a_last_ends_emit, clk, arst_n, rd_go && rd_last, !emit_q)

endmodule
`default_nettype wire

// File: sim/tb_srxl_frame_receiver_core.sv
`timescale 1ns / 100ps
// Testbench of the SRXL frame receiver core: directed frames, then checked random traffic.
module tb_srxl_frame_receiver_core;
	import srxl_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int ROWS = 19;
	localparam int PHASES = 3;

	typedef enum logic [2:0] {PH_IDLE, PH_DATA12, PH_DATA16, PH_CRC1, PH_CRC2} parse_phase_t;

	// One row of the directed table; tail holds the typed final result of a frame, if any
	typedef struct packed {
		logic       rtype;
		logic [7:0] value;
		logic [5:0] reps;
		logic       typed;
		out_item_t  tail;
	} stim_row_t;

	typedef struct packed {
		logic      typed;
		out_item_t tail;
		in_item_t  item;
	} send_item_t;

	typedef struct packed {
		logic [7:0] timeout;
		logic [4:0] min_ch;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
	logic [CFG_W-1:0] cfg_data = '0;

	// Predicted parser state and register copies
	logic [7:0] pred_timeout = TIMEOUT_RESET;
	logic [4:0] pred_min_ch = MIN_CH_RESET;
	parse_phase_t rx_phase = PH_IDLE;
	logic [4:0] rx_count = '0;
	logic rx_half = 1'b0;
	logic [7:0] rx_high = '0;
	logic [15:0] rx_store [MAX_CHANNELS] = '{default: '0};
	logic [7:0] rx_quiet = '0;
	logic rx_seen = 1'b0;
	logic rx_short = 1'b0;

	out_item_t expected_channels [$];
	send_item_t items_to_send [$];
	int items_queued = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int frames_done = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int burst_left = 1;
	int stall_mode = 0;
	int stall_tick = 0;
	logic sent_typed = 1'b0;
	out_item_t sent_tail = '0;

	// Directed items at reset settings: timeout 5, at least 12 channels
	stim_row_t directed_rows [ROWS] = '{
		'{REQ_TICK, 8'h00, 6'd3, 1'b0, '0},
		'{REQ_BYTE, 8'h00, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'hFF, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'hA0, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'hA3, 6'd1, 1'b0, '0},
		'{REQ_BYTE, HDR_SHORT, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'hFF, 6'd24, 1'b0, '0},
		'{REQ_BYTE, 8'h00, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'h00, 6'd1, 1'b1, '{4'd11, 16'hFFFF, 1'b1, 1'b1, 1'b1}},
		'{REQ_BYTE, HDR_LONG, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'h00, 6'd3, 1'b0, '0},
		'{REQ_TICK, 8'hFF, 6'd5, 1'b0, '0},
		'{REQ_BYTE, 8'h00, 6'd29, 1'b0, '0},
		'{REQ_BYTE, HDR_LONG, 6'd1, 1'b0, '0},
		'{REQ_BYTE, HDR_SHORT, 6'd1, 1'b1, '{4'd15, 16'h0000, 1'b0, 1'b1, 1'b1}},
		'{REQ_BYTE, HDR_SHORT, 6'd1, 1'b0, '0},
		'{REQ_BYTE, 8'h5A, 6'd3, 1'b0, '0},
		'{REQ_TICK, 8'h00, 6'd6, 1'b0, '0},
		'{REQ_BYTE, 8'h55, 6'd1, 1'b0, '0}
	};

	srxl_frame_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Advance the predicted parser by one item; push the channels a completed frame emits
	function automatic void parse_item(in_item_t it);
		int n;
		if (it.req_type == REQ_TICK) begin
			if (rx_quiet != 8'hFF)
				rx_quiet = rx_quiet + 8'd1;
			if (rx_phase != PH_IDLE && rx_quiet > pred_timeout)
				rx_phase = PH_IDLE;
			return;
		end
		rx_quiet = '0;
		case (rx_phase)
		PH_DATA12, PH_DATA16: begin
			if (rx_phase == PH_DATA12)
				rx_seen = 1'b1;
			if (!rx_half) begin
				rx_high = it.rx_byte;
				rx_half = 1'b1;
			end else begin
				if (rx_count < 5'd16)
					rx_store[rx_count[3:0]] = {rx_high, it.rx_byte};
				rx_count = rx_count + 5'd1;
				rx_half = 1'b0;
			end
			if ((rx_phase == PH_DATA12 && rx_count == SHORT_COUNT) || rx_count == LONG_COUNT)
				rx_phase = PH_CRC1;
		end
		PH_CRC1: begin
			rx_phase = PH_CRC2;
		end
		PH_CRC2: begin
			rx_phase = PH_IDLE;
			n = (rx_count > pred_min_ch) ? int'(rx_count) : int'(pred_min_ch);
			if (n > MAX_CHANNELS)
				n = MAX_CHANNELS;
			for (int i = 0; i < n; i++)
				expected_channels.push_back('{channel_index: 4'(i), channel_value: rx_store[i],
					frame_is_short: rx_short, seen_short_frame: rx_seen, last: (i == n - 1)});
			frames_done++;
		end
		default: begin
			if (it.rx_byte == HDR_SHORT) begin
				rx_phase = PH_DATA12;
				rx_short = 1'b1;
			end else if (it.rx_byte == HDR_LONG) begin
				rx_phase = PH_DATA16;
				rx_short = 1'b0;
			end else begin
				rx_phase = PH_IDLE;
			end
			rx_count = '0;
			rx_half = 1'b0;
		end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t ns: %s expected 'h%0h got 'h%0h", $time, name, want, got);
		end
	endfunction

	// Predict on each accepted item, then check each accepted result
	always @(posedge clk) begin : track_items
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_item(in_data);
				if (sent_typed && expected_channels.size() != 0) begin
					want = expected_channels.pop_back();
					expected_channels.push_back(sent_tail);
				end
				items_accepted++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_channels.size() == 0) begin
					fail_count++;
					$display("%0t ns: expected no result got index %0d value 'h%0h",
						$time, out_data.channel_index, out_data.channel_value);
				end else begin
					want = expected_channels.pop_front();
					check_field("channel_index", 16'(want.channel_index), 16'(out_data.channel_index));
					check_field("channel_value", want.channel_value, out_data.channel_value);
					check_field("frame_is_short", 16'(want.frame_is_short),
						16'(out_data.frame_is_short));
					check_field("seen_short_frame", 16'(want.seen_short_frame),
						16'(out_data.seen_short_frame));
					check_field("last", 16'(want.last), 16'(out_data.last));
				end
			end
		end
	end

	// Send items in bursts of random length with random gaps between them
	always @(posedge clk) begin : drive_items
		send_item_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (items_to_send.size() != 0) begin
				nxt = items_to_send.pop_front();
				in_valid <= 1'b1;
				in_data <= nxt.item;
				sent_typed <= nxt.typed;
				sent_tail <= nxt.tail;
				if (burst_left <= 1) begin
					gap_left <= $urandom_range(1, 6);
					burst_left <= ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall results on a pattern whose mode is redrawn at random from four modes
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 80 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= 1'($urandom_range(0, 1));
		2: out_stall <= (stall_tick % 4 != 0);
		default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t ns: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_item(logic rtype, logic [7:0] value, logic typed, out_item_t tail);
		send_item_t s;
		s.item.req_type = rtype;
		s.item.rx_byte = value;
		s.typed = typed;
		s.tail = tail;
		items_to_send.push_back(s);
		items_queued++;
	endtask

	// Hold until every item is taken and every expected channel has arrived
	task automatic settle_block();
		while (items_accepted != items_queued || expected_channels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write one register; drop the enable once the write is taken so writes never share a time step
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TIMEOUT)
			pred_timeout = value;
		else
			pred_min_ch = value[4:0];
		@(posedge clk);
	endtask

	// Queue optional noise, then one frame with random content, ticks within the
	// timeout and now and then a break that lets the frame time out below a timeout of 255
	task automatic queue_random_frame(output int pushed);
		int nbytes, cut, ticks;
		logic [7:0] b;
		pushed = 0;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(0, 255));
				if (b == HDR_SHORT || b == HDR_LONG)
					b = b ^ 8'h08;
				queue_item($urandom_range(0, 1) ? REQ_TICK : REQ_BYTE, b, 1'b0, '0);
			end
		end
		nbytes = $urandom_range(0, 1) ? 24 : 32;
		cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nbytes + 1) : -1;
		queue_item(REQ_BYTE, (nbytes == 24) ? HDR_SHORT : HDR_LONG, 1'b0, '0);
		pushed++;
		for (int j = 0; j < nbytes + 2; j++) begin
			if (j == cut) begin
				ticks = (pred_timeout == 8'hFF) ? 12 : int'(pred_timeout) + 1;
				repeat (ticks) queue_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
				pushed += ticks;
				return;
			end
			if (pred_timeout != 0 && $urandom_range(0, 4) == 0) begin
				ticks = $urandom_range(1, (pred_timeout < 4) ? int'(pred_timeout) : 4);
				repeat (ticks) queue_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
				pushed += ticks;
			end
			if ($urandom_range(0, 7) == 0)
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom_range(0, 255));
			queue_item(REQ_BYTE, b, 1'b0, '0);
			pushed++;
		end
	endtask

	initial begin
		stim_row_t row;
		setting_t plan [PHASES];
		int pushed, phase_items;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			for (int k = 0; k < row.reps; k++)
				queue_item(row.rtype, row.value, row.typed && (k == row.reps - 1), row.tail);
		end
		settle_block();

		// Random frames under several register settings, extremes included
		plan[0] = '{8'd0, 5'd31};
		plan[1] = '{8'd255, 5'd0};
		plan[2] = '{8'($urandom_range(1, 254)), 5'($urandom_range(1, 16))};
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_TIMEOUT, plan[p].timeout);
			write_reg(REG_MIN_CH, {3'b000, plan[p].min_ch});
			phase_items = 0;
			while (phase_items < 24) begin
				queue_random_frame(pushed);
				phase_items += pushed;
			end
			settle_block();
			// Finish any frame left open so the next setting starts from idle
			while (rx_phase != PH_IDLE) begin
				queue_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
				settle_block();
			end
		end

		$display("Covered %0d items and %0d channel results in %0d frames", items_accepted,
			results_seen, frames_done);
		$display("at reset and three other register settings with timeouts, gaps and stalls.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/srxl_pkg.sv
design/srxl_frame_receiver_core.sv
sim/tb_srxl_frame_receiver_core.sv
